// File: rtl/core/i2cm_pkg.sv
package i2cm_pkg;

    // Command codes carried in the op field.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_LONG_WAIT  = 1'b0;
    localparam logic CFG_SHORT_WAIT = 1'b1;

    localparam logic [7:0] LONG_WAIT_RESET  = 8'd5;
    localparam logic [7:0] SHORT_WAIT_RESET = 8'd2;
    localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

    typedef struct packed {
        logic       tick;
        logic       cmd_valid;
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       ack_on_read;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_oe;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } t_out;

endpackage

// File: rtl/core/i2c_master_byte_engine_top.sv
// I2C master byte controller. Every input transaction is one step of the bus sequencer
// (tick marks an elapsed time unit, cmd_valid starts START, STOP, WRITE or READ while
// idle) and produces exactly one output transaction showing the line drive and status
// after that step. The sequencer state advances by one step per accepted transaction, so the block
// takes one input transaction every cycle unless input is held off; the result appears in the output
// register in the cycle after acceptance, and input is held off only while a finished result is
// still waiting to be taken. Wait lengths are set by the two configuration registers
// and must only be written while no transaction is in flight.
module i2c_master_byte_engine_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  i2cm_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output i2cm_pkg::t_out    o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);
    import i2cm_pkg::*;

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_S_HIGH  = 5'd1;
    localparam logic [4:0] PH_S_SDALO = 5'd2;
    localparam logic [4:0] PH_S_SCLLO = 5'd3;
    localparam logic [4:0] PH_T_LOW   = 5'd4;
    localparam logic [4:0] PH_T_REL   = 5'd5;
    localparam logic [4:0] PH_W_SET   = 5'd6;
    localparam logic [4:0] PH_W_HIGH  = 5'd7;
    localparam logic [4:0] PH_W_LOW   = 5'd8;
    localparam logic [4:0] PH_W_AHIGH = 5'd9;
    localparam logic [4:0] PH_W_ALOW  = 5'd10;
    localparam logic [4:0] PH_R_HIGH  = 5'd11;
    localparam logic [4:0] PH_R_LOW   = 5'd12;
    localparam logic [4:0] PH_R_ASET  = 5'd13;
    localparam logic [4:0] PH_R_AHIGH = 5'd14;
    localparam logic [4:0] PH_R_ALOW  = 5'd15;
    localparam logic [4:0] PH_R_REL   = 5'd16;

    logic [7:0] r_long_wait;
    logic [7:0] r_short_wait;

    logic [4:0] r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_wait, n_wait;
    logic [7:0] r_tx_shift, n_tx_shift;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [1:0] r_cur_op, n_cur_op;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_oe, n_oe;
    logic       r_ack_flag, n_ack_flag;

    logic       r_out_valid;
    t_out       r_out, n_out;

    logic       accept;
    logic       act_en;
    logic [4:0] act_ph;
    logic [4:0] next_ph;
    logic [7:0] wait_long;
    logic [7:0] wait_short;
    logic [7:0] wait_dec;
    logic       done;
    logic       rejected;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A zero wait register behaves as a wait of one unit.
    assign wait_long  = (r_long_wait == 8'd0) ? 8'd1 : r_long_wait;
    assign wait_short = (r_short_wait == 8'd0) ? 8'd1 : r_short_wait;
    assign wait_dec   = (r_wait != 8'd0) ? r_wait - 8'd1 : 8'd0;

    always_comb begin
        unique case (r_phase)
            PH_S_HIGH:  next_ph = PH_S_SDALO;
            PH_S_SDALO: next_ph = PH_S_SCLLO;
            PH_T_LOW:   next_ph = PH_T_REL;
            PH_W_SET:   next_ph = PH_W_HIGH;
            PH_W_HIGH:  next_ph = PH_W_LOW;
            PH_W_LOW:   next_ph = (r_bit_count < BITS_PER_BYTE) ? PH_W_SET : PH_W_AHIGH;
            PH_W_AHIGH: next_ph = PH_W_ALOW;
            PH_R_HIGH:  next_ph = PH_R_LOW;
            PH_R_LOW:   next_ph = (r_bit_count < BITS_PER_BYTE) ? PH_R_HIGH : PH_R_ASET;
            PH_R_ASET:  next_ph = PH_R_AHIGH;
            PH_R_AHIGH: next_ph = PH_R_ALOW;
            PH_R_ALOW:  next_ph = PH_R_REL;
            default:    next_ph = PH_IDLE;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_wait       = r_wait;
        n_tx_shift   = r_tx_shift;
        n_rx_shift   = r_rx_shift;
        n_cur_op     = r_cur_op;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_oe         = r_oe;
        n_ack_flag   = r_ack_flag;
        act_en       = 1'b0;
        act_ph       = PH_IDLE;
        done         = 1'b0;
        rejected     = 1'b0;

        if (r_phase != PH_IDLE) begin
            rejected = i_in_data.cmd_valid;
            if (i_in_data.tick) begin
                n_wait = wait_dec;
                if (wait_dec == 8'd0) begin
                    act_en = 1'b1;
                    act_ph = next_ph;
                end
            end
        end else if (i_in_data.cmd_valid) begin
            n_cur_op    = i_in_data.op;
            n_bit_count = 4'd0;
            act_en      = 1'b1;
            unique case (i_in_data.op)
                OP_START: act_ph = PH_S_HIGH;
                OP_STOP:  act_ph = PH_T_LOW;
                OP_WRITE: begin
                    n_tx_shift = i_in_data.tx_byte;
                    act_ph     = PH_W_SET;
                end
                default: begin
                    n_ack_choice = i_in_data.ack_on_read;
                    n_rx_shift   = 8'd0;
                    act_ph       = PH_R_HIGH;
                end
            endcase
        end

        // Line action of the phase being entered. The two phases with no wait fall
        // straight through to idle in the same step.
        if (act_en) begin
            n_phase = act_ph;
            unique case (act_ph)
                PH_S_HIGH: begin
                    n_oe = 1'b1; n_scl = 1'b1; n_sda = 1'b1; n_wait = wait_long;
                end
                PH_S_SDALO: begin
                    n_sda = 1'b0; n_wait = wait_long;
                end
                PH_S_SCLLO: begin
                    n_scl = 1'b0; n_wait = 8'd0; n_phase = PH_IDLE; done = 1'b1;
                end
                PH_T_LOW: begin
                    n_oe = 1'b1; n_sda = 1'b0; n_scl = 1'b1; n_wait = wait_long;
                end
                PH_T_REL: begin
                    n_sda = 1'b1; n_wait = wait_long;
                end
                PH_W_SET: begin
                    n_oe = 1'b1; n_sda = n_tx_shift[7]; n_wait = wait_long;
                end
                PH_W_HIGH: begin
                    n_scl = 1'b1; n_wait = wait_long;
                end
                PH_W_LOW: begin
                    n_scl       = 1'b0;
                    n_tx_shift  = {r_tx_shift[6:0], 1'b0};
                    n_bit_count = r_bit_count + 4'd1;
                    n_wait      = wait_short;
                end
                PH_W_AHIGH: begin
                    n_oe = 1'b0; n_scl = 1'b1; n_wait = wait_long;
                end
                PH_W_ALOW: begin
                    n_ack_flag = !i_in_data.sda_in; n_scl = 1'b0; n_wait = wait_short;
                end
                PH_R_HIGH: begin
                    n_oe = 1'b0; n_scl = 1'b1; n_wait = wait_long;
                end
                PH_R_LOW: begin
                    n_rx_shift  = {r_rx_shift[6:0], i_in_data.sda_in};
                    n_scl       = 1'b0;
                    n_bit_count = r_bit_count + 4'd1;
                    n_wait      = wait_short;
                end
                PH_R_ASET: begin
                    n_oe = 1'b1; n_sda = !r_ack_choice; n_wait = wait_short;
                end
                PH_R_AHIGH: begin
                    n_scl = 1'b1; n_wait = wait_long;
                end
                PH_R_ALOW: begin
                    n_scl = 1'b0; n_wait = wait_short;
                end
                PH_R_REL: begin
                    n_oe = 1'b0; n_wait = 8'd0; n_phase = PH_IDLE; done = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE; done = 1'b1;
                end
            endcase
        end

        n_out.scl      = n_scl;
        n_out.sda_out  = n_oe ? n_sda : 1'b1;
        n_out.sda_oe   = n_oe;
        n_out.busy_res = (n_phase != PH_IDLE);
        n_out.done_res = done;
        n_out.rx_byte  = n_rx_shift;
        n_out.ack_seen = n_ack_flag;
        n_out.rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_wait  <= LONG_WAIT_RESET;
            r_short_wait <= SHORT_WAIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LONG_WAIT:  r_long_wait  <= i_cfg_data;
                CFG_SHORT_WAIT: r_short_wait <= i_cfg_data;
                default:        r_long_wait  <= r_long_wait;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 4'd0;
            r_wait       <= 8'd0;
            r_tx_shift   <= 8'd0;
            r_rx_shift   <= 8'd0;
            r_cur_op     <= OP_START;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_oe         <= 1'b0;
            r_ack_flag   <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_wait       <= n_wait;
            r_tx_shift   <= n_tx_shift;
            r_rx_shift   <= n_rx_shift;
            r_cur_op     <= n_cur_op;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_oe         <= n_oe;
            r_ack_flag   <= n_ack_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// File: tb/sv/i2c_master_byte_engine_top_tb.sv
`timescale 1ns / 100ps

module i2c_master_byte_engine_top_tb;
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        BS_IDLE,
        BS_START_HIGH,
        BS_START_SDA_LOW,
        BS_START_SCL_LOW,
        BS_STOP_LOW,
        BS_STOP_RELEASE,
        BS_WR_SETUP,
        BS_WR_HIGH,
        BS_WR_LOW,
        BS_WR_ACK_HIGH,
        BS_WR_ACK_LOW,
        BS_RD_HIGH,
        BS_RD_LOW,
        BS_RD_ACK_SETUP,
        BS_RD_ACK_HIGH,
        BS_RD_ACK_LOW,
        BS_RD_RELEASE
    } bus_step_e;

    typedef struct packed {
        bus_step_e  step;
        logic [3:0] bits;
        logic [7:0] wait_cnt;
        logic [7:0] tx_sr;
        logic [7:0] rx_sr;
        logic       ack_sel;
        logic       scl;
        logic       sda;
        logic       oe;
        logic       ack_flag;
        logic       done;
        logic       rejected;
    } bus_state_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    logic       cfg_we   = 1'b0;
    logic       cfg_idx  = 1'b0;
    logic [7:0] cfg_data = 8'd0;

    t_in  pending_items[$];
    t_out expected_results[$];
    t_out want_result;

    // line_model follows accepted transactions; plan_model runs ahead while items are planned.
    bus_state_t line_model;
    bus_state_t plan_model;
    logic [7:0] long_units  = LONG_WAIT_RESET;
    logic [7:0] short_units = SHORT_WAIT_RESET;

    logic [7:0] long_plan  [0:5] = '{8'd1, 8'd2, 8'd3, 8'd1, 8'd0, 8'd4};
    logic [7:0] short_plan [0:5] = '{8'd1, 8'd1, 8'd2, 8'd3, 8'd2, 8'd4};

    bit bus_open        = 1'b0;
    bit idle_on         = 1'b1;
    bit long_hold_armed = 1'b0;
    bit long_hold_done  = 1'b0;
    int gap_left        = 0;
    int stall_left      = 0;
    int long_hold_left  = 0;
    int error_count     = 0;
    int mismatch_count  = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int seqs_done       = 0;
    int cmds_rejected   = 0;

    i2c_master_byte_engine_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bus_step_e next_bus_step(bus_step_e cur, logic [3:0] bits);
        case (cur)
            BS_START_HIGH:    return BS_START_SDA_LOW;
            BS_START_SDA_LOW: return BS_START_SCL_LOW;
            BS_STOP_LOW:      return BS_STOP_RELEASE;
            BS_WR_SETUP:      return BS_WR_HIGH;
            BS_WR_HIGH:       return BS_WR_LOW;
            BS_WR_LOW:        return (bits < BITS_PER_BYTE) ? BS_WR_SETUP : BS_WR_ACK_HIGH;
            BS_WR_ACK_HIGH:   return BS_WR_ACK_LOW;
            BS_RD_HIGH:       return BS_RD_LOW;
            BS_RD_LOW:        return (bits < BITS_PER_BYTE) ? BS_RD_HIGH : BS_RD_ACK_SETUP;
            BS_RD_ACK_SETUP:  return BS_RD_ACK_HIGH;
            BS_RD_ACK_HIGH:   return BS_RD_ACK_LOW;
            BS_RD_ACK_LOW:    return BS_RD_RELEASE;
            default:          return BS_IDLE;
        endcase
    endfunction

    // Drives the lines for the step just entered and loads its wait.
    function automatic bus_state_t step_action(bus_state_t s, logic [7:0] lw, logic [7:0] sw,
                                               logic sda_in);
        logic [7:0] lw_eff;
        logic [7:0] sw_eff;
        lw_eff = (lw == 8'd0) ? 8'd1 : lw;
        sw_eff = (sw == 8'd0) ? 8'd1 : sw;
        s.wait_cnt = 8'd0;
        case (s.step)
            BS_START_HIGH: begin
                s.oe = 1'b1; s.scl = 1'b1; s.sda = 1'b1; s.wait_cnt = lw_eff;
            end
            BS_START_SDA_LOW: begin
                s.sda = 1'b0; s.wait_cnt = lw_eff;
            end
            BS_START_SCL_LOW: s.scl = 1'b0;
            BS_STOP_LOW: begin
                s.oe = 1'b1; s.sda = 1'b0; s.scl = 1'b1; s.wait_cnt = lw_eff;
            end
            BS_STOP_RELEASE: begin
                s.sda = 1'b1; s.wait_cnt = lw_eff;
            end
            BS_WR_SETUP: begin
                s.oe = 1'b1; s.sda = s.tx_sr[7]; s.wait_cnt = lw_eff;
            end
            BS_WR_HIGH: begin
                s.scl = 1'b1; s.wait_cnt = lw_eff;
            end
            BS_WR_LOW: begin
                s.scl = 1'b0;
                s.tx_sr = {s.tx_sr[6:0], 1'b0};
                s.bits = s.bits + 4'd1;
                s.wait_cnt = sw_eff;
            end
            BS_WR_ACK_HIGH: begin
                s.oe = 1'b0; s.scl = 1'b1; s.wait_cnt = lw_eff;
            end
            BS_WR_ACK_LOW: begin
                s.ack_flag = !sda_in; s.scl = 1'b0; s.wait_cnt = sw_eff;
            end
            BS_RD_HIGH: begin
                s.oe = 1'b0; s.scl = 1'b1; s.wait_cnt = lw_eff;
            end
            BS_RD_LOW: begin
                s.rx_sr = {s.rx_sr[6:0], sda_in};
                s.scl = 1'b0;
                s.bits = s.bits + 4'd1;
                s.wait_cnt = sw_eff;
            end
            BS_RD_ACK_SETUP: begin
                s.oe = 1'b1; s.sda = !s.ack_sel; s.wait_cnt = sw_eff;
            end
            BS_RD_ACK_HIGH: begin
                s.scl = 1'b1; s.wait_cnt = lw_eff;
            end
            BS_RD_ACK_LOW: begin
                s.scl = 1'b0; s.wait_cnt = sw_eff;
            end
            BS_RD_RELEASE: s.oe = 1'b0;
            default: ;
        endcase
        return s;
    endfunction

    // Walks through every step whose wait has already run out.
    function automatic bus_state_t settle_steps(bus_state_t s, logic [7:0] lw, logic [7:0] sw,
                                                logic sda_in);
        while (s.wait_cnt == 8'd0 && s.step != BS_IDLE) begin
            s.step = next_bus_step(s.step, s.bits);
            if (s.step == BS_IDLE)
                s.done = 1'b1;
            else
                s = step_action(s, lw, sw, sda_in);
        end
        return s;
    endfunction

    function automatic bus_state_t bus_advance(bus_state_t s, logic [7:0] lw, logic [7:0] sw,
                                               t_in it);
        s.done = 1'b0;
        s.rejected = 1'b0;
        if (s.step != BS_IDLE) begin
            if (it.cmd_valid)
                s.rejected = 1'b1;
            if (it.tick) begin
                if (s.wait_cnt != 8'd0)
                    s.wait_cnt = s.wait_cnt - 8'd1;
                s = settle_steps(s, lw, sw, it.sda_in);
            end
        end else if (it.cmd_valid) begin
            s.bits = 4'd0;
            case (it.op)
                OP_START: s.step = BS_START_HIGH;
                OP_STOP:  s.step = BS_STOP_LOW;
                OP_WRITE: begin
                    s.tx_sr = it.tx_byte;
                    s.step = BS_WR_SETUP;
                end
                default: begin
                    s.ack_sel = it.ack_on_read;
                    s.rx_sr = 8'd0;
                    s.step = BS_RD_HIGH;
                end
            endcase
            // A tick in the command's own transaction does not shorten the first wait.
            s = step_action(s, lw, sw, it.sda_in);
            s = settle_steps(s, lw, sw, it.sda_in);
        end
        return s;
    endfunction

    function automatic t_out bus_view(bus_state_t s);
        t_out r;
        r.scl      = s.scl;
        r.sda_out  = s.oe ? s.sda : 1'b1;
        r.sda_oe   = s.oe;
        r.busy_res = (s.step != BS_IDLE);
        r.done_res = s.done;
        r.rx_byte  = s.rx_sr;
        r.ack_seen = s.ack_flag;
        r.rejected = s.rejected;
        return r;
    endfunction

    function automatic string show_result(t_out r);
        return $sformatf("scl=%b sda=%b oe=%b busy=%b done=%b rx=%02h ack=%b rej=%b",
                         r.scl, r.sda_out, r.sda_oe, r.busy_res, r.done_res, r.rx_byte,
                         r.ack_seen, r.rejected);
    endfunction

    function automatic t_in make_cmd(logic [1:0] op, logic [7:0] data, logic ack, logic tick,
                                     logic sda);
        t_in t;
        t.tick        = tick;
        t.cmd_valid   = 1'b1;
        t.op          = op;
        t.tx_byte     = data;
        t.ack_on_read = ack;
        t.sda_in      = sda;
        return t;
    endfunction

    task automatic add_item(input t_in it);
        plan_model = bus_advance(plan_model, long_units, short_units, it);
        pending_items.push_back(it);
    endtask

    // Ticks until the running sequence ends; optionally a command lands in the ending item.
    task automatic finish_sequence(input logic sda, input logic cmd_at_end);
        t_in t;
        bus_state_t peek;
        while (plan_model.step != BS_IDLE) begin
            t = '0;
            t.tick = 1'b1;
            t.sda_in = sda;
            if (cmd_at_end) begin
                peek = bus_advance(plan_model, long_units, short_units, t);
                if (peek.step == BS_IDLE) begin
                    t.cmd_valid = 1'b1;
                    t.op = OP_READ;
                end
            end
            add_item(t);
        end
    endtask

    task automatic add_random_items(input int count);
        t_in t;
        int made;
        int pick;
        made = 0;
        while (made < count) begin
            t.tick        = $urandom_range(0, 1);
            t.cmd_valid   = 1'b0;
            t.op          = $urandom_range(0, 3);
            t.tx_byte     = $urandom_range(0, 255);
            t.ack_on_read = $urandom_range(0, 1);
            t.sda_in      = $urandom_range(0, 1);
            if (plan_model.step == BS_IDLE) begin
                if ($urandom_range(0, 6) != 0) begin
                    t.cmd_valid = 1'b1;
                    // Mostly a proper frame: START, data bytes, STOP.
                    if ($urandom_range(0, 9) != 0) begin
                        if (!bus_open) begin
                            t.op = OP_START;
                        end else begin
                            pick = $urandom_range(0, 9);
                            t.op = (pick < 4) ? OP_WRITE : (pick < 7) ? OP_READ :
                                   (pick < 8) ? OP_START : OP_STOP;
                        end
                    end
                    if (t.op == OP_START)
                        bus_open = 1'b1;
                    else if (t.op == OP_STOP)
                        bus_open = 1'b0;
                end
            end else begin
                t.tick      = ($urandom_range(0, 4) != 0);
                t.cmd_valid = ($urandom_range(0, 24) == 0);
            end
            if (t.tick || t.cmd_valid)
                made++;
            add_item(t);
        end
    endtask

    task automatic drain_block();
        int guard;
        guard = 0;
        while ((pending_items.size() != 0 || in_valid || expected_results.size() != 0) &&
               guard < 200000) begin
            @(negedge clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            error_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        if (idx == CFG_LONG_WAIT)
            long_units = value;
        else
            short_units = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                line_model = bus_advance(line_model, long_units, short_units, in_data);
                expected_results.push_back(bus_view(line_model));
                items_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 11) == 0)
                        gap_left <= $urandom_range(1, 12);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (out_data.done_res === 1'b1)
                    seqs_done++;
                if (out_data.rejected === 1'b1)
                    cmds_rejected++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (mismatch_count < 10)
                        $display("unexpected result: %s", show_result(out_data));
                    mismatch_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (out_data.scl !== want_result.scl ||
                        out_data.sda_out !== want_result.sda_out ||
                        out_data.sda_oe !== want_result.sda_oe ||
                        out_data.busy_res !== want_result.busy_res ||
                        out_data.done_res !== want_result.done_res ||
                        out_data.rx_byte !== want_result.rx_byte ||
                        out_data.ack_seen !== want_result.ack_seen ||
                        out_data.rejected !== want_result.rejected) begin
                        error_count++;
                        if (mismatch_count < 10)
                            $display("result %0d mismatch: expected %s, got %s",
                                     results_checked, show_result(want_result),
                                     show_result(out_data));
                        mismatch_count++;
                    end
                end
            end
            // One long hold-off lets the output back up until the input stalls.
            if (long_hold_left != 0) begin
                long_hold_left <= long_hold_left - 1;
                out_ready <= 1'b0;
            end else if (long_hold_armed && !long_hold_done) begin
                long_hold_done <= 1'b1;
                long_hold_left <= 300;
                out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 11) == 0)
                    stall_left <= $urandom_range(1, 12);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        line_model     = '0;
        line_model.scl = 1'b1;
        line_model.sda = 1'b1;
        plan_model     = line_model;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset wait values first.
        @(negedge clk);
        add_random_items(30);
        finish_sequence(1'b1, 1'b0);
        drain_block();

        // Zero in both registers acts as a one-unit wait.
        write_cfg(CFG_LONG_WAIT, 8'd0);
        write_cfg(CFG_SHORT_WAIT, 8'd0);
        @(negedge clk);
        add_item(t_in'{tick: 1'b1, cmd_valid: 1'b0, op: OP_START, tx_byte: 8'h00,
                       ack_on_read: 1'b0, sda_in: 1'b1});
        add_item(make_cmd(OP_START, 8'h00, 1'b0, 1'b1, 1'b1));
        add_item(make_cmd(OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1));
        finish_sequence(1'b1, 1'b0);
        add_item(make_cmd(OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0));
        add_item(t_in'{tick: 1'b0, cmd_valid: 1'b0, op: OP_READ, tx_byte: 8'hFF,
                       ack_on_read: 1'b1, sda_in: 1'b0});
        finish_sequence(1'b0, 1'b0);
        add_item(make_cmd(OP_WRITE, 8'h00, 1'b1, 1'b1, 1'b1));
        finish_sequence(1'b1, 1'b1);
        add_item(make_cmd(OP_READ, 8'h00, 1'b1, 1'b0, 1'b1));
        finish_sequence(1'b1, 1'b0);
        add_item(make_cmd(OP_READ, 8'hA5, 1'b0, 1'b1, 1'b0));
        finish_sequence(1'b0, 1'b1);
        add_item(make_cmd(OP_WRITE, 8'h5A, 1'b0, 1'b1, 1'b0));
        finish_sequence(1'b1, 1'b0);
        add_item(make_cmd(OP_STOP, 8'hFF, 1'b1, 1'b0, 1'b0));
        finish_sequence(1'b0, 1'b0);
        drain_block();

        // The largest long wait, then a long short wait, each used by one short sequence.
        write_cfg(CFG_LONG_WAIT, 8'd255);
        write_cfg(CFG_SHORT_WAIT, 8'd1);
        @(negedge clk);
        add_item(make_cmd(OP_START, 8'h00, 1'b0, 1'b1, 1'b1));
        finish_sequence(1'b1, 1'b1);
        drain_block();
        write_cfg(CFG_LONG_WAIT, 8'd1);
        write_cfg(CFG_SHORT_WAIT, 8'd12);
        @(negedge clk);
        add_item(make_cmd(OP_WRITE, 8'hC3, 1'b0, 1'b1, 1'b0));
        finish_sequence(1'b0, 1'b0);
        drain_block();

        for (int k = 0; k < 6; k++) begin
            write_cfg(CFG_LONG_WAIT, long_plan[k]);
            write_cfg(CFG_SHORT_WAIT, short_plan[k]);
            @(negedge clk);
            if (k == 5)
                idle_on = 1'b0;
            add_random_items(15);
            finish_sequence($urandom_range(0, 1), 1'b0);
            if (k == 1)
                long_hold_armed = 1'b1;
            drain_block();
        end

        $display("covered %0d accepted items under reset, zero, extreme and random wait values",
                 items_accepted);
        $display("%0d results checked, %0d sequences completed, %0d busy commands rejected",
                 results_checked, seqs_done, cmds_rejected);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: i2c_master_byte_engine_top.f
rtl/core/i2cm_pkg.sv
rtl/core/i2c_master_byte_engine_top.sv
tb/sv/i2c_master_byte_engine_top_tb.sv
